// File: rtl/dnsqm_pkg.sv
// Shared types and constants for the DNS header and question matcher.
// No dependencies.
`default_nettype none
package dnsqm_pkg;
  localparam int unsigned HdrLen = 12;

  typedef struct packed {
    logic        qry;
    logic [15:0] id;
    logic [15:0] qtype;
  } job_t;

  typedef struct packed {
    logic        parse_ok;
    logic        qr;
    logic [3:0]  dns_opcode;
    logic [3:0]  rcode;
    logic [5:0]  header_flags;
    logic [15:0] question_type;
    logic [15:0] question_count;
    logic [15:0] answer_count;
    logic [15:0] authority_count;
    logic [15:0] additional_count;
    logic [15:0] transaction_id;
  } hdr_t;

  function automatic logic [1:0] mod3(input logic [15:0] v);
    logic [1:0] r;
    r = 2'd0;
    for (int i = 15; i >= 0; i--) begin
      unique case ({r, v[i]})
        3'b000: r = 2'd0;
        3'b001: r = 2'd1;
        3'b010: r = 2'd2;
        3'b011: r = 2'd0;
        3'b100: r = 2'd1;
        default: r = 2'd2;
      endcase
    end
    return r;
  endfunction
endpackage
`default_nettype wire

// File: rtl/dnsqm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none
module dnsqm_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  wire                     clk_i,
  input  wire                     we_i,
  input  wire [$clog2(Depth)-1:0] waddr_i,
  input  wire [Width-1:0]         wdata_i,
  input  wire [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]        rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// File: rtl/dnsqm_front.sv
// Front end: byte parser for header and first question.
// Depends on dnsqm_pkg.
`default_nettype none
module dnsqm_front #(
  parameter int unsigned PositionWidth = 16
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                valid_i,
  output logic               ready_o,
  input  wire                clear_i,
  input  wire [7:0]          byte_i,
  input  wire                last_i,
  output logic               clr_o,
  output logic               job_valid_o,
  input  wire                job_ready_i,
  output dnsqm_pkg::hdr_t    hdr_o,
  output dnsqm_pkg::job_t    job_o
);
  import dnsqm_pkg::*;
  localparam logic [1:0] PhStart = 2'd0, PhIn = 2'd1, PhDone = 2'd2, PhBad = 2'd3;
  localparam logic [PositionWidth-1:0] PosMax = '1;

  logic [PositionWidth-1:0] pos_q, nend_q, len;
  logic [15:0] hw_q [6];
  logic [1:0]  ph_q;
  logic [7:0]  rem_q;
  logic [15:0] tb_q;
  logic        long_q;
  logic        take, ok;
  logic [15:0] qt;

  // only a closing word or a clear has to wait for the back end
  assign ready_o = job_ready_i || (!clear_i && !last_i);
  assign take = valid_i && ready_o && !clear_i;
  assign clr_o = valid_i && ready_o && clear_i;
  assign job_valid_o = take && last_i;
  assign len = pos_q + 1'b1;
  assign ok = !long_q && pos_q != PosMax && pos_q >= PositionWidth'(HdrLen - 1);

  always_comb begin
    logic [15:0] t;
    t = tb_q;
    if (ph_q == PhDone && pos_q == nend_q) t[15:8] = byte_i;
    if (ph_q == PhDone && pos_q == nend_q + 1'b1) t[7:0] = byte_i;
    qt = 16'd0;
    if (hw_q[2] != 16'd0 && ph_q == PhDone &&
        {1'b0, nend_q} + (PositionWidth+1)'(4) <= {1'b0, len})
      qt = t;
    if (pos_q == PositionWidth'(HdrLen - 1)) qt = 16'd0;
  end

  always_comb begin
    logic [15:0] h[6];
    for (int i = 0; i < 6; i++) h[i] = hw_q[i];
    if (pos_q == PositionWidth'(HdrLen - 1)) h[5][7:0] = byte_i;
    hdr_o = '0;
    if (ok) begin
      hdr_o.parse_ok = 1'b1;
      hdr_o.qr = h[1][15];
      hdr_o.dns_opcode = h[1][14:11];
      hdr_o.rcode = h[1][3:0];
      hdr_o.header_flags = {h[1][10:7], h[1][5:4]};
      hdr_o.question_type = qt;
      hdr_o.question_count = h[2];
      hdr_o.answer_count = h[3];
      hdr_o.authority_count = h[4];
      hdr_o.additional_count = h[5];
      hdr_o.transaction_id = h[0];
    end
    job_o.qry = !h[1][15];
    job_o.id = h[0];
    job_o.qtype = qt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0; nend_q <= '0; ph_q <= PhStart; rem_q <= '0; tb_q <= '0;
      long_q <= 1'b0;
      for (int i = 0; i < 6; i++) hw_q[i] <= '0;
    end else if (clr_o || (take && last_i)) begin
      pos_q <= '0; nend_q <= '0; ph_q <= PhStart; rem_q <= '0; tb_q <= '0;
      long_q <= 1'b0;
      for (int i = 0; i < 6; i++) hw_q[i] <= '0;
    end else if (take) begin
      if (long_q || pos_q == PosMax) long_q <= 1'b1;
      else begin
        pos_q <= len;
        if (pos_q < PositionWidth'(HdrLen)) begin
          if (pos_q[0]) hw_q[pos_q[3:1]][7:0] <= byte_i;
          else hw_q[pos_q[3:1]][15:8] <= byte_i;
        end else begin
          unique case (ph_q)
            PhStart: begin
              if (byte_i == 8'd0) begin ph_q <= PhDone; nend_q <= len; end
              else if (byte_i[7:6] == 2'b11) begin
                ph_q <= PhDone; nend_q <= pos_q + 2'd2;
              end else if (byte_i[7:6] == 2'b00) begin
                ph_q <= PhIn; rem_q <= byte_i;
              end else ph_q <= PhBad;
            end
            PhIn: begin
              rem_q <= rem_q - 1'b1;
              if (rem_q == 8'd1) ph_q <= PhStart;
            end
            PhDone: begin
              if (pos_q == nend_q) tb_q[15:8] <= byte_i;
              else if (pos_q == nend_q + 1'b1) tb_q[7:0] <= byte_i;
            end
            default: ;
          endcase
        end
      end
    end
  end
endmodule
`default_nettype wire

// File: rtl/dnsqm_back.sv
// Back end: query history ring, serial search for responses, result register.
// Depends on dnsqm_pkg and dnsqm_ram.
`default_nettype none
module dnsqm_back #(
  parameter int unsigned HistoryDepth = 256
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               clr_i,
  input  wire               job_valid_i,
  output logic              job_ready_o,
  input  dnsqm_pkg::hdr_t   hdr_i,
  input  dnsqm_pkg::job_t   job_i,
  output logic              res_valid_o,
  input  wire               res_ready_i,
  output dnsqm_pkg::hdr_t   res_o,
  output logic [3:0]        status_o
);
  import dnsqm_pkg::*;
  localparam int unsigned Aw = $clog2(HistoryDepth);
  localparam logic [1:0] StIdle = 2'd0, StSearch = 2'd1, StOut = 2'd2;

  logic [1:0] st_q;
  logic [Aw:0] cnt_q, idx_q;
  logic [Aw-1:0] head_q;
  logic rd_pend_q, hit_q;
  hdr_t hdr_q;
  logic [31:0] rdata;
  logic we, accept;
  logic [Aw-1:0] raddr;

  assign job_ready_o = (st_q == StIdle) || (st_q == StOut && res_ready_i);
  assign accept = job_valid_i && job_ready_o;
  assign we = accept && hdr_i.parse_ok && job_i.qry;
  assign res_valid_o = st_q == StOut;
  assign res_o = hdr_q;
  assign raddr = idx_q[Aw-1:0];

  dnsqm_ram #(.Width(32), .Depth(HistoryDepth)) u_ram (
    .clk_i, .we_i(we), .waddr_i(head_q), .wdata_i({job_i.id, job_i.qtype}),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  always_comb begin
    status_o = 4'd0;
    if (hdr_q.parse_ok) begin
      if (!hdr_q.qr) status_o[2] = 1'b1;
      else begin
        status_o[0] = hit_q;
        if (hit_q && hdr_q.answer_count != 16'd0 && hdr_q.rcode == 4'd0) begin
          if (mod3(hdr_q.transaction_id) == 2'd0) status_o[1] = 1'b1;
          else status_o[2] = 1'b1;
        end
        status_o[3] = hdr_q.rcode == 4'd0 || hdr_q.rcode == 4'd3;
      end
    end
  end

  always_ff @(posedge clk_i) if (accept) hdr_q <= hdr_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; cnt_q <= '0; head_q <= '0; idx_q <= '0;
      rd_pend_q <= 1'b0; hit_q <= 1'b0;
    end else begin
      if (st_q == StOut && res_ready_i && !accept) st_q <= StIdle;
      if (clr_i) begin cnt_q <= '0; head_q <= '0; end
      if (accept) begin
        hit_q <= 1'b0; idx_q <= '0; rd_pend_q <= 1'b0;
        if (hdr_i.parse_ok && !hdr_i.qr) st_q <= StOut;
        else if (hdr_i.parse_ok) st_q <= StSearch;
        else st_q <= StOut;
        if (we) begin
          head_q <= (head_q == Aw'(HistoryDepth - 1)) ? '0 : head_q + 1'b1;
          if (cnt_q != (Aw+1)'(HistoryDepth)) cnt_q <= cnt_q + 1'b1;
        end
      end else if (st_q == StSearch) begin
        if (rd_pend_q && rdata == {hdr_q.transaction_id, hdr_q.question_type})
          hit_q <= 1'b1;
        if (idx_q < cnt_q) begin
          idx_q <= idx_q + 1'b1; rd_pend_q <= 1'b1;
        end else begin
          rd_pend_q <= 1'b0;
          if (!rd_pend_q) st_q <= StOut;
        end
      end
    end
  end
endmodule
`default_nettype wire

// File: rtl/dns_message_query_matcher.sv
// Top level of the DNS header and question matcher.
// Depends on dnsqm_pkg, dnsqm_front, dnsqm_back.
//
// Bytes enter one per cycle; only the last byte of a message and a clear wait
// while the back end is busy. On the last byte the parsed header goes to the
// back end; a query or malformed message is offered in the cycle after its
// last byte, while a response first scans the query history one entry a cycle
// through the registered read port of the history RAM in the search state and
// is offered once the scan ends. Opcode 1 clears the history and any partial
// message.
`default_nettype none
module dns_message_query_matcher #(
  parameter int unsigned HISTORY_DEPTH = 256,
  parameter int unsigned POSITION_WIDTH = 16
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  input  wire  [7:0]   s_axis_tdata,  // data_byte
  input  wire          s_axis_tuser,  // opcode
  input  wire          s_axis_tlast,  // last_byte
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  output logic [119:0] m_axis_tdata   // parse_ok, is_response, dns_opcode, rcode,
                                      // header_flags, question_type, question_count,
                                      // answer_count, authority_count,
                                      // additional_count, transaction_id, match_status
);
  import dnsqm_pkg::*;
  logic jv, jr, clr;
  hdr_t hdr, res;
  job_t job;
  logic [3:0] stat;

  dnsqm_front #(.PositionWidth(POSITION_WIDTH)) u_front (
    .clk_i, .rst_ni, .valid_i(s_axis_tvalid), .ready_o(s_axis_tready),
    .clear_i(s_axis_tuser), .byte_i(s_axis_tdata), .last_i(s_axis_tlast),
    .clr_o(clr), .job_valid_o(jv), .job_ready_i(jr), .hdr_o(hdr), .job_o(job)
  );

  dnsqm_back #(.HistoryDepth(HISTORY_DEPTH)) u_back (
    .clk_i, .rst_ni, .clr_i(clr), .job_valid_i(jv), .job_ready_o(jr),
    .hdr_i(hdr), .job_i(job), .res_valid_o(m_axis_tvalid),
    .res_ready_i(m_axis_tready), .res_o(res), .status_o(stat)
  );

  assign m_axis_tdata = {4'd0, stat, res.transaction_id, res.additional_count,
    res.authority_count, res.answer_count, res.question_count, res.question_type,
    res.header_flags, res.rcode, res.dns_opcode, res.qr, res.parse_ok};
endmodule
`default_nettype wire

// File: test/dnsqm_checker.sv
// Checker for the DNS header and question matcher: watches both stream channels,
// predicts every result word from the accepted input words and compares.
// Depends on the DUT port layout only.
`timescale 1ns / 1ps
module dnsqm_checker (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          s_valid_i,
  input  wire          s_ready_i,
  input  wire  [7:0]   s_data_i,
  input  wire          s_user_i,
  input  wire          s_last_i,
  input  wire          m_valid_i,
  input  wire          m_ready_i,
  input  wire  [119:0] m_data_i,
  output int           fails_o,
  output int           pending_o
);
  localparam int Depth  = 256;
  localparam int PosMax = 65535;

  typedef enum logic [1:0] {NmStart, NmInLabel, NmDone, NmBad} name_st_e;

  typedef struct packed {
    logic        parse_ok;
    logic        qr;
    logic [3:0]  dns_opcode;
    logic [3:0]  rcode;
    logic [5:0]  header_flags;
    logic [15:0] question_type;
    logic [15:0] question_count;
    logic [15:0] answer_count;
    logic [15:0] authority_count;
    logic [15:0] additional_count;
    logic [15:0] transaction_id;
    logic [3:0]  match_status;
  } verdict_t;

  verdict_t    verdicts_due[$];
  int          pos;
  logic [15:0] hw[6];
  name_st_e    nst;
  logic [7:0]  lrem;
  int          name_end;
  logic [15:0] qtype_acc;
  bit          overlong;
  logic [15:0] seen_ids[Depth];
  logic [15:0] seen_types[Depth];
  int          seen_cnt;
  int          seen_head;

  task automatic report(string what, logic [15:0] got, logic [15:0] want);
    $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
    fails_o++;
  endtask

  function automatic void drop_message();
    pos = 0;
    foreach (hw[i]) hw[i] = '0;
    nst = NmStart;
    lrem = '0;
    name_end = 0;
    qtype_acc = '0;
    overlong = 0;
  endfunction

  function automatic void absorb_byte(int idx, logic [7:0] b);
    if (idx < 12) begin
      if (idx % 2) hw[idx/2][7:0] = b;
      else hw[idx/2][15:8] = b;
      return;
    end
    case (nst)
      NmStart: begin
        if (b == 8'h00) begin
          nst = NmDone;
          name_end = idx + 1;
        end else if (b[7:6] == 2'b11) begin
          nst = NmDone;
          name_end = idx + 2;
        end else if (b[7:6] == 2'b00) begin
          nst = NmInLabel;
          lrem = b;
        end else begin
          nst = NmBad;
        end
      end
      NmInLabel: begin
        lrem = lrem - 8'd1;
        if (lrem == 0) nst = NmStart;
      end
      NmDone: begin
        if (idx == name_end) qtype_acc[15:8] = b;
        else if (idx == name_end + 1) qtype_acc[7:0] = b;
      end
      default: ;
    endcase
  endfunction

  function automatic verdict_t close_message(int len);
    verdict_t v;
    logic [15:0] flags;
    logic [15:0] qt;
    bit hit;
    v = '0;
    if (overlong || len < 12) return v;
    flags = hw[1];
    qt = '0;
    if (hw[2] != 0 && nst == NmDone && name_end + 4 <= len) qt = qtype_acc;
    if (!flags[15]) begin
      seen_ids[seen_head] = hw[0];
      seen_types[seen_head] = qt;
      seen_head = (seen_head + 1) % Depth;
      if (seen_cnt < Depth) seen_cnt++;
      v.match_status[2] = 1'b1;
    end else begin
      hit = 0;
      for (int i = 0; i < seen_cnt; i++)
        if (seen_ids[i] == hw[0] && seen_types[i] == qt) hit = 1;
      if (hit) begin
        v.match_status[0] = 1'b1;
        if (hw[3] != 0 && flags[3:0] == 0) begin
          if (hw[0] % 3 == 0) v.match_status[1] = 1'b1;
          else v.match_status[2] = 1'b1;
        end
      end
      if (flags[3:0] == 0 || flags[3:0] == 3) v.match_status[3] = 1'b1;
    end
    v.parse_ok = 1'b1;
    v.qr = flags[15];
    v.dns_opcode = flags[14:11];
    v.rcode = flags[3:0];
    v.header_flags = {flags[10:7], flags[5:4]};
    v.question_type = qt;
    v.question_count = hw[2];
    v.answer_count = hw[3];
    v.authority_count = hw[4];
    v.additional_count = hw[5];
    v.transaction_id = hw[0];
    return v;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    int idx;
    verdict_t want;
    verdict_t got;
    if (!rst_ni) begin
      drop_message();
      seen_cnt = 0;
      seen_head = 0;
      fails_o = 0;
    end else begin
      if (s_valid_i && s_ready_i) begin
        if (s_user_i) begin
          seen_cnt = 0;
          seen_head = 0;
          drop_message();
        end else begin
          idx = pos;
          if (overlong || idx >= PosMax) begin
            overlong = 1;
          end else begin
            absorb_byte(idx, s_data_i);
            pos = idx + 1;
          end
          if (s_last_i) begin
            verdicts_due.push_back(close_message(idx + 1));
            drop_message();
          end
        end
      end
      if (m_valid_i && m_ready_i) begin
        // fields packed from bit 0: parse_ok first, match_status last
        got.parse_ok = m_data_i[0];
        got.qr = m_data_i[1];
        got.dns_opcode = m_data_i[5:2];
        got.rcode = m_data_i[9:6];
        got.header_flags = m_data_i[15:10];
        got.question_type = m_data_i[31:16];
        got.question_count = m_data_i[47:32];
        got.answer_count = m_data_i[63:48];
        got.authority_count = m_data_i[79:64];
        got.additional_count = m_data_i[95:80];
        got.transaction_id = m_data_i[111:96];
        got.match_status = m_data_i[115:112];
        if (verdicts_due.size() == 0) begin
          report("unexpected word", got.transaction_id, '0);
        end else begin
          want = verdicts_due.pop_front();
          if (got.parse_ok != want.parse_ok) report("parse_ok", got.parse_ok, want.parse_ok);
          if (got.qr != want.qr) report("qr", got.qr, want.qr);
          if (got.dns_opcode != want.dns_opcode)
            report("dns_opcode", got.dns_opcode, want.dns_opcode);
          if (got.rcode != want.rcode) report("rcode", got.rcode, want.rcode);
          if (got.header_flags != want.header_flags)
            report("header_flags", got.header_flags, want.header_flags);
          if (got.question_type != want.question_type)
            report("question_type", got.question_type, want.question_type);
          if (got.question_count != want.question_count)
            report("question_count", got.question_count, want.question_count);
          if (got.answer_count != want.answer_count)
            report("answer_count", got.answer_count, want.answer_count);
          if (got.authority_count != want.authority_count)
            report("authority_count", got.authority_count, want.authority_count);
          if (got.additional_count != want.additional_count)
            report("additional_count", got.additional_count, want.additional_count);
          if (got.transaction_id != want.transaction_id)
            report("transaction_id", got.transaction_id, want.transaction_id);
          if (got.match_status != want.match_status)
            report("match_status", got.match_status, want.match_status);
        end
      end
    end
    pending_o = verdicts_due.size();
  end

  final begin
    if (verdicts_due.size() != 0)
      $display("%0d result words never arrived", verdicts_due.size());
  end
endmodule

// File: test/tb_dns_message_query_matcher.sv
// Testbench top for the DNS header and question matcher: drives message words,
// stalls both sides at random and gives the verdict. Depends on dnsqm_checker
// and the DUT.
`timescale 1ns / 1ps
module tb_dns_message_query_matcher;
  localparam int StallLimit = 20000;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = '0;  // data_byte
  logic         s_axis_tuser = 1'b0;  // opcode
  logic         s_axis_tlast = 1'b0;  // last_byte
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [119:0] m_axis_tdata;
  int           fails;
  int           pending;
  int           src_idle;
  int           dst_idle;
  int           quiet_cycles;
  int           bytes_sent;
  logic [7:0]   msg[$];
  logic [15:0]  asked_ids[$];
  logic [15:0]  asked_types[$];

  always #5 clk_i = ~clk_i;

  dns_message_query_matcher dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  dnsqm_checker u_checker (
    .clk_i, .rst_ni,
    .s_valid_i(s_axis_tvalid), .s_ready_i(s_axis_tready), .s_data_i(s_axis_tdata),
    .s_user_i(s_axis_tuser), .s_last_i(s_axis_tlast),
    .m_valid_i(m_axis_tvalid), .m_ready_i(m_axis_tready), .m_data_i(m_axis_tdata),
    .fails_o(fails), .pending_o(pending)
  );

  always @(negedge clk_i) m_axis_tready <= ($urandom_range(99) >= dst_idle);

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_ni) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic put_word(bit op, logic [7:0] b, bit last);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser = op;
    s_axis_tdata = b;
    s_axis_tlast = last;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
  endtask

  task automatic send_msg();
    foreach (msg[i]) put_word(1'b0, msg[i], i == msg.size() - 1);
    msg.delete();
  endtask

  task automatic clear_history();
    put_word(1'b1, 8'($urandom_range(255)), 1'($urandom_range(1)));
  endtask

  function automatic void put16(logic [15:0] v);
    msg.push_back(v[15:8]);
    msg.push_back(v[7:0]);
  endfunction

  function automatic void header(logic [15:0] id, logic [15:0] flags, logic [15:0] qd,
                                 logic [15:0] an);
    put16(id);
    put16(flags);
    put16(qd);
    put16(an);
    put16(16'($urandom));
    put16(16'($urandom));
  endfunction

  // name of random labels, then a terminator, a pointer or a bad label byte, qtype and qclass
  function automatic void question(logic [15:0] qt, int ending);
    int labels;
    int len;
    labels = $urandom_range(3);
    repeat (labels) begin
      len = ($urandom_range(15) == 0) ? 63 : $urandom_range(1, 6);
      msg.push_back(8'(len));
      repeat (len) msg.push_back(8'($urandom));
    end
    case (ending)
      0: msg.push_back(8'h00);
      1: begin
        msg.push_back({2'b11, 6'($urandom)});
        msg.push_back(8'($urandom));
      end
      default: msg.push_back({($urandom_range(1) ? 2'b01 : 2'b10), 6'($urandom)});
    endcase
    put16(qt);
    put16(16'($urandom));
  endfunction

  task automatic dns_message(bit resp);
    logic [15:0] id;
    logic [15:0] qt;
    logic [15:0] flags;
    logic [15:0] qd;
    int pick;
    int ending;
    int cut;
    id = 16'($urandom);
    qt = ($urandom_range(1)) ? 16'($urandom_range(1, 33)) : 16'($urandom);
    if (resp && asked_ids.size() > 0 && $urandom_range(9) < 7) begin
      pick = $urandom_range(asked_ids.size() - 1);
      id = asked_ids[pick];
      qt = asked_types[pick];
    end
    flags = 16'($urandom);
    flags[15] = resp;
    case ($urandom_range(3))
      0: flags[3:0] = 4'd0;
      1: flags[3:0] = 4'd3;
      default: ;
    endcase
    qd = ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(1, 3));
    ending = ($urandom_range(19) < 17) ? 0 : ($urandom_range(1) ? 1 : 2);
    header(id, flags, qd, ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom));
    question(qt, ending);
    if ($urandom_range(6) == 0) begin
      cut = $urandom_range(1, 4);
      repeat (cut) void'(msg.pop_back());
    end else if ($urandom_range(3) == 0) begin
      repeat ($urandom_range(1, 8)) msg.push_back(8'($urandom));
    end
    if (!resp) begin
      asked_ids.push_back(id);
      asked_types.push_back(qt);
      if (asked_ids.size() > 32) begin
        void'(asked_ids.pop_front());
        void'(asked_types.pop_front());
      end
    end
    send_msg();
  endtask

  task automatic random_phase(int budget);
    int stop;
    int roll;
    stop = bytes_sent + budget;
    while (bytes_sent < stop) begin
      roll = $urandom_range(99);
      if (roll < 75) begin
        dns_message(1'($urandom_range(1)));
      end else if (roll < 85) begin
        repeat ($urandom_range(1, 30)) msg.push_back(8'($urandom));
        send_msg();
      end else if (roll < 92) begin
        repeat ($urandom_range(1, 20)) put_word(1'b0, 8'($urandom), 1'b0);
        clear_history();
      end else begin
        clear_history();
      end
    end
  endtask

  initial begin
    src_idle = 12;
    dst_idle = 69;
    bytes_sent = 0;
    quiet_cycles = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // query then matching responses, plain and with rcode 3
    header(16'h0000, 16'h0100, 16'd1, 16'd0);
    question(16'h0001, 0);
    send_msg();
    header(16'h0000, 16'h8180, 16'd1, 16'd1);
    question(16'h0001, 0);
    send_msg();
    header(16'h0000, 16'h8183, 16'd1, 16'd0);
    question(16'h0001, 0);
    send_msg();
    // all ones header, response with no match
    header(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    question(16'hFFFF, 0);
    send_msg();
    // pointer name, query and response with id not divisible by 3
    header(16'h0001, 16'h0000, 16'd1, 16'd0);
    question(16'h001C, 1);
    send_msg();
    header(16'h0001, 16'h8000, 16'd1, 16'd2);
    question(16'h001C, 1);
    send_msg();
    // bad label types
    header(16'h1234, 16'h0000, 16'd1, 16'd0);
    msg.push_back(8'h40);
    put16(16'h0001);
    send_msg();
    header(16'h1235, 16'h0000, 16'd1, 16'd0);
    msg.push_back(8'h80);
    put16(16'h0001);
    send_msg();
    // zero qdcount; qtype cut short
    header(16'h2222, 16'h0000, 16'd0, 16'd0);
    question(16'h0005, 0);
    send_msg();
    header(16'h2223, 16'h0000, 16'd1, 16'd0);
    msg.push_back(8'h00);
    put16(16'h000F);
    msg.push_back(8'h00);
    send_msg();
    // short messages
    msg.push_back(8'hA5);
    send_msg();
    repeat (11) msg.push_back(8'($urandom));
    send_msg();
    // clear, then the earlier query no longer matches; partial message dropped
    clear_history();
    repeat (5) put_word(1'b0, 8'($urandom), 1'b0);
    clear_history();
    header(16'h0000, 16'h8100, 16'd1, 16'd1);
    question(16'h0001, 0);
    send_msg();

    random_phase(300);
    src_idle = 69;
    dst_idle = 12;
    random_phase(290);
    src_idle = 0;
    dst_idle = 0;
    random_phase(290);

    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
